/* rtl/core/lmlt_pkg.sv */
// Shared types and constants for the LCD mode and line timer.
// No dependencies; every other file of the block uses this package.
package lmlt_pkg;

	// display modes, encoded as the status register reports them
	typedef enum logic [1:0] {
		PHASE_HBLANK = 2'd0,
		PHASE_VBLANK = 2'd1,
		PHASE_OAM    = 2'd2,
		PHASE_VRAM   = 2'd3
	} mode_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_LCD_ENABLE   = 3'd0,
		REG_LINE_COMPARE = 3'd1,
		REG_COINC_IRQ_EN = 3'd2,
		REG_OAM_IRQ_EN   = 3'd3,
		REG_HBLANK_IRQ_EN = 3'd4,
		REG_VBLANK_IRQ_EN = 3'd5
	} reg_idx_t;

	localparam int unsigned ElapsedW = 6;
	localparam int unsigned DotW     = 10;
	localparam int unsigned LineW    = 8;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 8;

	localparam logic [DotW-1:0]  DOTS_OAM     = 10'd80;
	localparam logic [DotW-1:0]  DOTS_VRAM    = 10'd172;
	localparam logic [DotW-1:0]  DOTS_HBLANK  = 10'd204;
	localparam logic [DotW-1:0]  DOTS_LINE    = 10'd456;
	localparam logic [LineW-1:0] LAST_VISIBLE = 8'd143;
	localparam logic [LineW-1:0] LAST_LINE    = 8'd153;

	// configuration register file contents
	typedef struct packed {
		logic             lcd_enable;
		logic [LineW-1:0] line_compare;
		logic             coinc_irq_en;
		logic             oam_irq_en;
		logic             hblank_irq_en;
		logic             vblank_irq_en;
	} cfg_t;

	// timing state carried from one transaction to the next
	typedef struct packed {
		logic [DotW-1:0]  dot;
		mode_t            mode;
		logic [LineW-1:0] line;
		logic             coincide;
	} timer_state_t;

	// per-transaction event flags
	typedef struct packed {
		logic vblank_irq;
		logic stat_irq;
		logic render_pulse;
	} event_flags_t;

endpackage

/* rtl/core/lmlt_ifs.sv */
// Handshake interfaces for the LCD mode and line timer channels.
// Depends on lmlt_pkg for field widths.
interface lmlt_step_if;
	logic                              valid;
	logic                              ready;
	logic [lmlt_pkg::ElapsedW-1:0]     elapsed;
	modport source (output valid, output elapsed, input ready);
	modport sink (input valid, input elapsed, output ready);
endinterface

interface lmlt_status_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     cur_mode;
	logic [lmlt_pkg::LineW-1:0]     cur_line;
	logic                           coincide;
	logic                           vblank_irq;
	logic                           stat_irq;
	logic                           render_pulse;
	modport source (output valid, output cur_mode, output cur_line, output coincide,
		output vblank_irq, output stat_irq, output render_pulse, input ready);
	modport sink (input valid, input cur_mode, input cur_line, input coincide,
		input vblank_irq, input stat_irq, input render_pulse, output ready);
endinterface

interface lmlt_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [lmlt_pkg::CfgIdxW-1:0]    addr;
	logic [lmlt_pkg::CfgDataW-1:0]   data;
	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

/* rtl/core/lmlt_cfg_regs.sv */
// Configuration register file of the LCD mode and line timer.
// Depends on lmlt_pkg and the lmlt_cfg_if interface.
module lmlt_cfg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	lmlt_cfg_if.sink             cfg,
	output lmlt_pkg::cfg_t       regs
);

	lmlt_pkg::cfg_t regs_q;

	// always take writes
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// decode the register index; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid) begin
			unique case (lmlt_pkg::reg_idx_t'(cfg.addr))
				lmlt_pkg::REG_LCD_ENABLE:    regs_q.lcd_enable    <= cfg.data[0];
				lmlt_pkg::REG_LINE_COMPARE:  regs_q.line_compare  <= cfg.data;
				lmlt_pkg::REG_COINC_IRQ_EN:  regs_q.coinc_irq_en  <= cfg.data[0];
				lmlt_pkg::REG_OAM_IRQ_EN:    regs_q.oam_irq_en    <= cfg.data[0];
				lmlt_pkg::REG_HBLANK_IRQ_EN: regs_q.hblank_irq_en <= cfg.data[0];
				lmlt_pkg::REG_VBLANK_IRQ_EN: regs_q.vblank_irq_en <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule

/* rtl/core/lmlt_step.sv */
// Next-state logic of the LCD mode and line timer: one dot-count step.
// Depends on lmlt_pkg.
module lmlt_step (
	input  lmlt_pkg::cfg_t                   cfg,
	input  lmlt_pkg::timer_state_t           cur,
	input  logic [lmlt_pkg::ElapsedW-1:0]    elapsed,
	output lmlt_pkg::timer_state_t           nxt,
	output lmlt_pkg::event_flags_t           flags
);

	logic [lmlt_pkg::DotW-1:0]  sum;
	logic [lmlt_pkg::LineW-1:0] line_inc;
	logic [lmlt_pkg::LineW-1:0] cmp_line;
	logic                       enter;
	lmlt_pkg::mode_t            new_mode;
	logic                       match;

	assign sum      = cur.dot + {{(lmlt_pkg::DotW-lmlt_pkg::ElapsedW){1'b0}}, elapsed};
	assign line_inc = cur.line + 8'd1;
	assign match    = (cmp_line == cfg.line_compare);

	// advance the dot counter, take at most one transition, raise events on mode entry
	always_comb begin
		nxt      = cur;
		flags    = '0;
		enter    = 1'b0;
		new_mode = cur.mode;
		cmp_line = cur.line;
		if (cfg.lcd_enable) begin
			nxt.dot = sum;
			unique case (cur.mode)
				lmlt_pkg::PHASE_OAM: begin
					if (sum >= lmlt_pkg::DOTS_OAM) begin
						nxt.dot  = sum - lmlt_pkg::DOTS_OAM;
						enter    = 1'b1;
						new_mode = lmlt_pkg::PHASE_VRAM;
					end
				end
				lmlt_pkg::PHASE_VRAM: begin
					if (sum >= lmlt_pkg::DOTS_VRAM) begin
						nxt.dot            = sum - lmlt_pkg::DOTS_VRAM;
						enter              = 1'b1;
						new_mode           = lmlt_pkg::PHASE_HBLANK;
						flags.render_pulse = 1'b1;
					end
				end
				lmlt_pkg::PHASE_HBLANK: begin
					if (sum >= lmlt_pkg::DOTS_HBLANK) begin
						nxt.dot  = sum - lmlt_pkg::DOTS_HBLANK;
						nxt.line = line_inc;
						cmp_line = line_inc;
						enter    = 1'b1;
						new_mode = (cur.line == lmlt_pkg::LAST_VISIBLE) ?
							lmlt_pkg::PHASE_VBLANK : lmlt_pkg::PHASE_OAM;
					end
				end
				lmlt_pkg::PHASE_VBLANK: begin
					if (sum >= lmlt_pkg::DOTS_LINE) begin
						nxt.dot  = sum - lmlt_pkg::DOTS_LINE;
						nxt.line = line_inc;
						// leaving the last line: compare sees one past it, then wrap
						if (cur.line == lmlt_pkg::LAST_LINE) begin
							cmp_line = line_inc;
							enter    = 1'b1;
							new_mode = lmlt_pkg::PHASE_OAM;
							nxt.line = '0;
						end
					end
				end
				default: ;
			endcase
			if (enter) begin
				nxt.mode     = new_mode;
				nxt.coincide = match;
				flags.stat_irq = (match && cfg.coinc_irq_en)
					|| (new_mode == lmlt_pkg::PHASE_OAM && cfg.oam_irq_en)
					|| (new_mode == lmlt_pkg::PHASE_HBLANK && cfg.hblank_irq_en)
					|| (new_mode == lmlt_pkg::PHASE_VBLANK && cfg.vblank_irq_en);
				flags.vblank_irq = (new_mode == lmlt_pkg::PHASE_VBLANK);
			end
		end
	end

endmodule

/* rtl/core/lcd_mode_line_timer_unit.sv */
// Top level of the LCD mode and line timer: input stage, timing state, result register.
// Depends on lmlt_pkg, the lmlt interfaces, lmlt_cfg_regs and lmlt_step.
//
//   channel  role    payload
//   step     sink    elapsed (6b)
//   status   source  cur_mode, cur_line, coincide, vblank_irq, stat_irq, render_pulse
//   cfg      sink    addr (3b), data (8b); always ready
//
// A transaction enters the input stage, and its result is registered into the status
// register when the input stage moves on; one transaction per cycle is sustained while
// status does not stall. The step logic between the input stage and the timing state
// is combinational. A stall on status holds the result register and the input stage;
// step takes a new transaction whenever the input stage is empty or moves on. Reset clears
// the timing state, configuration and valid flags to idle values with no clearing pass.
module lcd_mode_line_timer_unit (
	input  logic            clk,
	input  logic            arst_n,
	lmlt_step_if.sink       step,
	lmlt_status_if.source   status,
	lmlt_cfg_if.sink        cfg
);

	lmlt_pkg::cfg_t                    regs;
	lmlt_pkg::timer_state_t            state_q;
	lmlt_pkg::timer_state_t            state_nxt;
	lmlt_pkg::event_flags_t            flags;
	logic                              valid_s1;
	logic [lmlt_pkg::ElapsedW-1:0]     elapsed_s1;
	logic                              out_valid_q;
	lmlt_pkg::timer_state_t            out_state_q;
	lmlt_pkg::event_flags_t            out_flags_q;
	logic                              advance;

	lmlt_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	lmlt_step u_step (
		.cfg     (regs),
		.cur     (state_q),
		.elapsed (elapsed_s1),
		.nxt     (state_nxt),
		.flags   (flags)
	);

	// the input stage moves on when the result register is free or being drained
	assign advance    = valid_s1 && (!out_valid_q || status.ready);
	assign step.ready = !valid_s1 || advance;

	// hold the accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (step.ready) begin
			valid_s1 <= step.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step.valid && step.ready) begin
			elapsed_s1 <= step.elapsed;
		end
	end

	// commit the timing state as each transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{dot: '0, mode: lmlt_pkg::PHASE_HBLANK, line: '0, coincide: 1'b0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_state_q <= state_nxt;
			out_flags_q <= flags;
		end
	end

	assign status.valid        = out_valid_q;
	assign status.cur_mode     = out_state_q.mode;
	assign status.cur_line     = out_state_q.line;
	assign status.coincide     = out_state_q.coincide;
	assign status.vblank_irq   = out_flags_q.vblank_irq;
	assign status.stat_irq     = out_flags_q.stat_irq;
	assign status.render_pulse = out_flags_q.render_pulse;

	// dot counter stays below a full line
	a_dot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.dot < lmlt_pkg::DOTS_LINE)
		else $error("dot counter out of range");

	// stored line never reaches one past the last line
	a_line_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.line <= lmlt_pkg::LAST_LINE)
		else $error("line counter out of range");

	// a render pulse is reported only on entry to hblank
	a_render_mode: assert property (@(posedge clk) disable iff (!arst_n)
		advance && flags.render_pulse |=> out_state_q.mode == lmlt_pkg::PHASE_HBLANK)
		else $error("render pulse outside hblank entry");

	// a vblank interrupt comes with vblank mode on line 144
	a_vblank_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_flags_q.vblank_irq |->
		out_state_q.mode == lmlt_pkg::PHASE_VBLANK && out_state_q.line == 8'd144)
		else $error("vblank interrupt without vblank entry");

endmodule

/* test/lmlt_status_checker.sv */
// Status checker for the LCD mode and line timer: predicts every status transaction.
// Depends on lmlt_pkg and the lmlt channel interfaces; watches them, never drives them.
module lmlt_status_checker
	import lmlt_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	lmlt_step_if          step,
	lmlt_status_if        status,
	lmlt_cfg_if           cfg,
	output int            errors,
	output int            pending,
	output int            checked,
	output int            wraps,
	output logic [LineW-1:0] line_now
);

	typedef struct packed {
		mode_t            mode;
		logic [LineW-1:0] line;
		logic             coincide;
		event_flags_t     ev;
	} status_exp_t;

	cfg_t          cfg_q;
	timer_state_t  st;
	status_exp_t   due_status_q[$];
	int            err_cnt;
	int            chk_cnt;
	int            wrap_cnt;

	// Compare one field of a status transaction
	task automatic check_field(input string fname, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", fname, want, got);
			err_cnt++;
		end
	endtask

	// Enter a mode: compare the line, collect interrupts, latch the mode
	task automatic switch_mode(input mode_t m, inout logic vbl, inout logic stat);
		if (st.line == cfg_q.line_compare) begin
			st.coincide = 1'b1;
			if (cfg_q.coinc_irq_en)
				stat = 1'b1;
		end else begin
			st.coincide = 1'b0;
		end
		if (m == PHASE_OAM && cfg_q.oam_irq_en)
			stat = 1'b1;
		if (m == PHASE_HBLANK && cfg_q.hblank_irq_en)
			stat = 1'b1;
		if (m == PHASE_VBLANK) begin
			vbl = 1'b1;
			if (cfg_q.vblank_irq_en)
				stat = 1'b1;
		end
		st.mode = m;
	endtask

	// Advance the timing by one step transaction and form the expected status
	task automatic predict_status(input logic [ElapsedW-1:0] el, output status_exp_t r);
		logic [LineW-1:0] ly;
		logic vbl;
		logic stat;
		logic rend;
		vbl = 1'b0;
		stat = 1'b0;
		rend = 1'b0;
		if (cfg_q.lcd_enable) begin
			ly = st.line;
			st.dot = st.dot + {{(DotW-ElapsedW){1'b0}}, el};
			case (st.mode)
				PHASE_OAM: begin
					if (st.dot >= DOTS_OAM) begin
						st.dot = st.dot - DOTS_OAM;
						switch_mode(PHASE_VRAM, vbl, stat);
					end
				end
				PHASE_VRAM: begin
					if (st.dot >= DOTS_VRAM) begin
						st.dot = st.dot - DOTS_VRAM;
						switch_mode(PHASE_HBLANK, vbl, stat);
						rend = 1'b1;
					end
				end
				PHASE_HBLANK: begin
					if (st.dot >= DOTS_HBLANK) begin
						st.dot = st.dot - DOTS_HBLANK;
						st.line = ly + 8'd1;
						if (ly == LAST_VISIBLE)
							switch_mode(PHASE_VBLANK, vbl, stat);
						else
							switch_mode(PHASE_OAM, vbl, stat);
					end
				end
				default: begin
					if (st.dot >= DOTS_LINE) begin
						st.dot = st.dot - DOTS_LINE;
						st.line = ly + 8'd1;
						// frame wrap: the compare sees the line one past the last
						if (ly == LAST_LINE) begin
							switch_mode(PHASE_OAM, vbl, stat);
							st.line = '0;
							wrap_cnt++;
						end
					end
				end
			endcase
		end
		r.mode = st.mode;
		r.line = st.line;
		r.coincide = st.coincide;
		r.ev.vblank_irq = vbl;
		r.ev.stat_irq = stat;
		r.ev.render_pulse = rend;
	endtask

	// Track configuration, queue predictions, check results in order
	always @(posedge clk or negedge arst_n) begin
		status_exp_t e;
		if (!arst_n) begin
			cfg_q = '0;
			st.dot = '0;
			st.mode = PHASE_HBLANK;
			st.line = '0;
			st.coincide = 1'b0;
			due_status_q.delete();
			err_cnt = 0;
			chk_cnt = 0;
			wrap_cnt = 0;
			errors <= 0;
			pending <= 0;
			checked <= 0;
			wraps <= 0;
			line_now <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.addr)
					REG_LCD_ENABLE:    cfg_q.lcd_enable = cfg.data[0];
					REG_LINE_COMPARE:  cfg_q.line_compare = cfg.data;
					REG_COINC_IRQ_EN:  cfg_q.coinc_irq_en = cfg.data[0];
					REG_OAM_IRQ_EN:    cfg_q.oam_irq_en = cfg.data[0];
					REG_HBLANK_IRQ_EN: cfg_q.hblank_irq_en = cfg.data[0];
					REG_VBLANK_IRQ_EN: cfg_q.vblank_irq_en = cfg.data[0];
					default: ;
				endcase
			end
			// check before queueing, so a stray result never meets a fresh prediction
			if (status.valid && status.ready) begin
				if (due_status_q.size() == 0) begin
					$error("status transaction with no prediction waiting");
					err_cnt++;
				end else begin
					e = due_status_q.pop_front();
					chk_cnt++;
					check_field("cur_mode", 8'(e.mode), 8'(status.cur_mode));
					check_field("cur_line", e.line, status.cur_line);
					check_field("coincide", 8'(e.coincide), 8'(status.coincide));
					check_field("vblank_irq", 8'(e.ev.vblank_irq), 8'(status.vblank_irq));
					check_field("stat_irq", 8'(e.ev.stat_irq), 8'(status.stat_irq));
					check_field("render_pulse", 8'(e.ev.render_pulse),
						8'(status.render_pulse));
				end
			end
			if (step.valid && step.ready) begin
				predict_status(step.elapsed, e);
				due_status_q.push_back(e);
			end
			errors <= err_cnt;
			pending <= due_status_q.size();
			checked <= chk_cnt;
			wraps <= wrap_cnt;
			line_now <= st.line;
		end
	end

endmodule

/* test/tb_top.sv */
// Testbench top for lcd_mode_line_timer_unit: clock, reset, stimulus and verdict.
// Depends on lmlt_pkg, the lmlt interfaces, the block and lmlt_status_checker.
module tb_top;
	import lmlt_pkg::*;

	localparam logic [CfgIdxW-1:0] IDX_UNUSED_LO = 3'd6;
	localparam logic [CfgIdxW-1:0] IDX_UNUSED_HI = 3'd7;

	logic clk;
	logic arst_n;

	lmlt_step_if   step_ch ();
	lmlt_status_if status_ch ();
	lmlt_cfg_if    cfg_ch ();

	int errors;
	int pending;
	int checked;
	int wraps;
	logic [LineW-1:0] line_now;
	int sent;
	int settings_cnt;

	lcd_mode_line_timer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step_ch),
		.status (status_ch),
		.cfg    (cfg_ch)
	);

	lmlt_status_checker status_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step_ch),
		.status   (status_ch),
		.cfg      (cfg_ch),
		.errors   (errors),
		.pending  (pending),
		.checked  (checked),
		.wraps    (wraps),
		.line_now (line_now)
	);

	always #5 clk = ~clk;

	// Stop a hung run
	initial begin
		#3000000;
		$display("DONE: errors detected");
		$finish;
	end

	// Receiver stall pattern: switch between always ready, sparse stalls and long stalls
	int rdy_style = 0;
	int rdy_left = 0;
	int hold_cnt = 0;
	always @(posedge clk) begin
		if (rdy_left == 0) begin
			rdy_style <= $urandom_range(0, 2);
			rdy_left <= $urandom_range(32, 200);
		end else begin
			rdy_left <= rdy_left - 1;
		end
		case (rdy_style)
			0: status_ch.ready <= 1'b1;
			1: status_ch.ready <= ($urandom_range(0, 3) != 0);
			default: begin
				if (hold_cnt != 0) begin
					hold_cnt <= hold_cnt - 1;
				end else begin
					status_ch.ready <= !status_ch.ready;
					hold_cnt <= $urandom_range(0, 9);
				end
			end
		endcase
	end

	// Send one step transaction and hold it until accepted
	task automatic push_item(input logic [ElapsedW-1:0] el);
		step_ch.valid <= 1'b1;
		step_ch.elapsed <= el;
		do @(posedge clk); while (step_ch.ready !== 1'b1);
		sent++;
	endtask

	// Write one register, then drop valid for a cycle
	task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop sending and wait until every predicted status has arrived
	task automatic drain();
		step_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int burst;
		int gap;
		int left;
		int sel;
		logic [ElapsedW-1:0] el;
		logic [LineW-1:0] lc;
		logic lcd_on;
		logic [3:0] en_bits;

		clk = 1'b0;
		arst_n = 1'b0;
		step_ch.valid = 1'b0;
		step_ch.elapsed = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.addr = '0;
		cfg_ch.data = '0;
		sent = 0;
		settings_cnt = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// LCD off out of reset: state must hold
		push_item(6'd63);
		push_item(6'd0);
		drain();

		// Unused indexes are ignored; enable bit taken from bit 0 only
		cfg_write(IDX_UNUSED_LO, 8'hFF);
		cfg_write(IDX_UNUSED_HI, 8'hFF);
		cfg_write(REG_LCD_ENABLE, 8'hFE);
		cfg_write(REG_LINE_COMPARE, 8'd1);
		cfg_write(REG_COINC_IRQ_EN, 8'hFF);
		cfg_write(REG_OAM_IRQ_EN, 8'hFF);
		cfg_write(REG_HBLANK_IRQ_EN, 8'hFF);
		cfg_write(REG_VBLANK_IRQ_EN, 8'hFF);
		settings_cnt++;
		push_item(6'd63);
		drain();

		// Walk hblank, oam (line match), vram, hblank with a render pulse, then oam again
		cfg_write(REG_LCD_ENABLE, 8'h81);
		settings_cnt++;
		push_item(6'd0);
		repeat (4) push_item(6'd63);
		push_item(6'd42);
		push_item(6'd21);
		push_item(6'd1);
		push_item(6'd32);
		repeat (6) push_item(6'd63);
		push_item(6'd0);
		drain();

		// Random phases: new settings each time, bursts of mostly large counts
		while (sent < 1000 || wraps == 0) begin
			lcd_on = ($urandom_range(0, 9) != 0);
			if (line_now >= 8'd140 && $urandom_range(0, 1) == 1) begin
				lc = 8'd154;
			end else begin
				case ($urandom_range(0, 4))
					0: lc = line_now + 8'($urandom_range(1, 8));
					1: lc = 8'd0;
					2: lc = 8'hFF;
					3: lc = 8'($urandom_range(143, 153));
					default: lc = 8'($urandom);
				endcase
			end
			case ($urandom_range(0, 3))
				0: en_bits = 4'h0;
				1: en_bits = 4'hF;
				default: en_bits = 4'($urandom);
			endcase
			cfg_write(REG_LINE_COMPARE, lc);
			cfg_write(REG_COINC_IRQ_EN, {7'($urandom), en_bits[0]});
			cfg_write(REG_OAM_IRQ_EN, {7'($urandom), en_bits[1]});
			cfg_write(REG_HBLANK_IRQ_EN, {7'($urandom), en_bits[2]});
			cfg_write(REG_VBLANK_IRQ_EN, {7'($urandom), en_bits[3]});
			if ($urandom_range(0, 7) == 0)
				cfg_write($urandom_range(0, 1) ? IDX_UNUSED_HI : IDX_UNUSED_LO, 8'($urandom));
			cfg_write(REG_LCD_ENABLE, {7'($urandom), lcd_on});
			settings_cnt++;

			left = lcd_on ? $urandom_range(60, 250) : $urandom_range(8, 24);
			while (left > 0) begin
				burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 120)
					: $urandom_range(1, 16);
				if (burst > left)
					burst = left;
				for (int i = 0; i < burst; i++) begin
					sel = $urandom_range(0, 99);
					if (sel < 4)
						el = 6'd0;
					else if (sel < 50)
						el = 6'd63;
					else if (sel < 60)
						el = 6'($urandom_range(0, 63));
					else
						el = 6'($urandom_range(50, 63));
					push_item(el);
				end
				left -= burst;
				// idle between bursts, sometimes not at all
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
				if (gap > 0 && left > 0) begin
					step_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			drain();
		end

		repeat (8) @(posedge clk);
		$display("Covered %0d step transactions under %0d register settings,",
			sent, settings_cnt);
		$display("%0d status transactions checked, %0d frame wraps.", checked, wraps);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
